FILE: src/ramdac_hidden_register_port_unit_defines.svh
// assertion macros shared by the hidden register port sources
`ifndef RAMDAC_HIDDEN_REGISTER_PORT_UNIT_DEFINES_SVH
`define RAMDAC_HIDDEN_REGISTER_PORT_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define HRP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define HRP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/hrp_pkg.sv
package hrp_pkg;

  // extended register file
  localparam int EXT_REG_COUNT = 256;
  localparam int EXT_AW = (EXT_REG_COUNT > 1) ? $clog2(EXT_REG_COUNT) : 1;

  // port addresses
  localparam logic [15:0] PORT_MASK    = 16'h03C6;
  localparam logic [15:0] PORT_RD_ADDR = 16'h03C7;
  localparam logic [15:0] PORT_WR_ADDR = 16'h03C8;
  localparam logic [15:0] PORT_DATA    = 16'h03C9;

  // access kinds
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // fixed read values
  localparam logic [7:0] ID_BYTE0  = 8'h44;
  localparam logic [7:0] ID_BYTE1  = 8'h02;
  localparam logic [7:0] FILL_BYTE = 8'hFF;

  // command register bits
  localparam int CMD_EXT_DEPTH_BIT = 3;
  localparam int CMD_EXT_SEQ_BIT   = 4;

  // unlock counter codes
  localparam logic [2:0] CNT_CMD    = 3'd4;
  localparam logic [2:0] CNT_IDX_LO = 3'd5;
  localparam logic [2:0] CNT_IDX_HI = 3'd6;
  localparam logic [2:0] CNT_DATA   = 3'd7;

  // depth codes
  localparam logic [1:0] DEPTH_8BPP  = 2'd0;
  localparam logic [1:0] DEPTH_15BPP = 2'd1;
  localparam logic [1:0] DEPTH_16BPP = 2'd2;
  localparam logic [1:0] DEPTH_24BPP = 2'd3;

  // unlock counter step tables
  localparam logic [2:0] READ_NEXT_PLAIN [8] =
    '{3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd0, 3'd0, 3'd0};
  localparam logic [2:0] READ_NEXT_EXT [8] =
    '{3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7, 3'd7};
  localparam logic [2:0] WRITE_NEXT [8] =
    '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd6, 3'd7, 3'd7};

  // result queue
  localparam int OUTQ_DEPTH = 3;
  localparam int OUTQ_AW = 2;

  typedef struct packed {
    logic        kind;
    logic [15:0] port_address;
    logic [7:0]  write_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       forwarded;
    logic [1:0] depth_code;
  } out_item_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [EXT_AW-1:0] addr;
    logic [7:0]        wdata;
  } mem_req_t;

  typedef struct packed {
    logic       use_mem;
    logic [7:0] rd_imm;
    logic       forwarded;
    logic [1:0] depth_code;
  } s1_item_t;

  function automatic logic [1:0] decode_depth(input logic [7:0] cmd, input logic [7:0] reg3);
    logic [1:0] d;
    d = DEPTH_8BPP;
    if (cmd[CMD_EXT_DEPTH_BIT]) begin
      unique case (reg3) inside
        8'd1, 8'd2, 8'd8: d = DEPTH_15BPP;
        8'd3, 8'd6:       d = DEPTH_16BPP;
        8'd4, 8'd9:       d = DEPTH_24BPP;
        default:          d = DEPTH_8BPP;
      endcase
    end else begin
      unique case (cmd[7:5])
        3'd5:    d = DEPTH_15BPP;
        3'd6:    d = DEPTH_16BPP;
        3'd7:    d = DEPTH_24BPP;
        default: d = DEPTH_8BPP;
      endcase
    end
    return d;
  endfunction

endpackage

FILE: src/ramdac_hidden_register_port_unit.sv
// hidden register port of a true-colour ramdac, one i/o access per beat
// input channel: in_valid / in_stall / in_item carries kind, port_address and
//   write_data of one bus access; a beat moves when in_valid is high and
//   in_stall is low
// output channel: out_valid / out_stall / out_item gives read_data, the
//   forwarded flag for the standard dac and the current depth_code, one
//   result beat per input beat, in order
// pipeline: the input beat updates the counter, command, index and issues the
//   ram access into the stage one register, and stage one merges the ram
//   read data into the result queue, from which the result is offered
// throughput: one access per cycle unless stalled; the ram is read or written
//   at most once per access and the index and counter update in the same cycle
// in_stall comes from the result queue fill plus the beat in stage one, so
//   input keeps flowing while a finished result waits; once the receiver holds
//   out_stall long enough to fill the queue, input stalls too, and resumes
//   the cycle after the receiver takes a beat
// reset: rst_n low at a clk edge clears the unlock counter, command,
//   index, depth and the ram valid bits at once, so every extended register
//   past the id bytes at index 0 and 1 reads zero; no clearing pass is needed
module ramdac_hidden_register_port_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  hrp_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output hrp_pkg::out_item_t out_item
);
  import hrp_pkg::*;

  logic      acc;
  mem_req_t  mem_req;
  logic [7:0] mem_rdata;
  logic      s1_valid;
  s1_item_t  s1_item;
  out_item_t s1_out;
  logic      q_block;

  // input beat taken
  assign acc      = in_valid && !in_stall;
  assign in_stall = q_block;

  // counter, command, index and depth state plus ram request
  hrp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc_i     (acc),
    .item_i    (in_item),
    .mem_req_o (mem_req),
    .s1_valid_o(s1_valid),
    .s1_item_o (s1_item)
  );

  // extended register file, one access per cycle
  hrp_ram u_ram (
    .clk      (clk),
    .rst_n    (rst_n),
    .mem_req_i(mem_req),
    .rdata_o  (mem_rdata)
  );

  // ram-backed data reads take the ram byte, everything else the immediate value
  assign s1_out.read_data  = s1_item.use_mem ? mem_rdata : s1_item.rd_imm;
  assign s1_out.forwarded  = s1_item.forwarded;
  assign s1_out.depth_code = s1_item.depth_code;

  // result queue decouples the receiver's stall from the input side
  hrp_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_i     (s1_valid),
    .item_i     (s1_out),
    .out_stall_i(out_stall),
    .out_valid_o(out_valid),
    .out_item_o (out_item),
    .block_o    (q_block)
  );

endmodule

FILE: src/hrp_ram.sv
module hrp_ram (
  input  logic             clk,
  input  logic             rst_n,
  input  hrp_pkg::mem_req_t mem_req_i,
  output logic [7:0]       rdata_o
);
  import hrp_pkg::*;

  logic [7:0]               mem_r [EXT_REG_COUNT];
  logic [EXT_REG_COUNT-1:0] valid_r;
  logic [7:0]               rdata_r;
  logic                     rvalid_r;

  always_ff @(posedge clk) begin
    if (mem_req_i.we) begin
      mem_r[mem_req_i.addr] <= mem_req_i.wdata;
    end
  end

  // never-written entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (mem_req_i.we) begin
      valid_r[mem_req_i.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_req_i.re) begin
      rdata_r  <= mem_r[mem_req_i.addr];
      rvalid_r <= valid_r[mem_req_i.addr];
    end
  end

  assign rdata_o = rvalid_r ? rdata_r : 8'h00;

endmodule

FILE: src/hrp_ctrl.sv
`include "ramdac_hidden_register_port_unit_defines.svh"

module hrp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc_i,
  input  hrp_pkg::in_item_t item_i,
  output hrp_pkg::mem_req_t mem_req_o,
  output logic              s1_valid_o,
  output hrp_pkg::s1_item_t s1_item_o
);
  import hrp_pkg::*;

  logic [2:0]  cnt_r, cnt_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [15:0] idx_r, idx_nxt;
  logic [7:0]  reg3_r, reg3_nxt;
  logic [1:0]  depth_r, depth_nxt;
  logic        s1_valid_r;
  s1_item_t    s1_r, s1_nxt;
  logic        is_mask;
  logic        in_range;

  assign is_mask  = (item_i.port_address == PORT_MASK);
  assign in_range = (idx_r < 16'(EXT_REG_COUNT));

  always_comb begin
    cnt_nxt           = cnt_r;
    cmd_nxt           = cmd_r;
    idx_nxt           = idx_r;
    reg3_nxt          = reg3_r;
    depth_nxt         = depth_r;
    mem_req_o.we      = 1'b0;
    mem_req_o.re      = 1'b0;
    mem_req_o.addr    = idx_r[EXT_AW-1:0];
    mem_req_o.wdata   = item_i.write_data;
    s1_nxt.use_mem    = 1'b0;
    s1_nxt.rd_imm     = 8'h00;
    s1_nxt.forwarded  = 1'b1;
    if (acc_i) begin
      if (item_i.kind == KIND_WRITE) begin
        if (is_mask) begin
          case (cnt_r)
            CNT_CMD:    cmd_nxt = item_i.write_data;
            CNT_IDX_LO: idx_nxt = {idx_r[15:8], item_i.write_data};
            CNT_IDX_HI: idx_nxt = {item_i.write_data, idx_r[7:0]};
            CNT_DATA: begin
              if (in_range) begin
                mem_req_o.we = 1'b1;
                if (idx_r == 16'd3) begin
                  reg3_nxt = item_i.write_data;
                end
              end
              idx_nxt = idx_r + 16'd1;
            end
            default: ;
          endcase
          s1_nxt.forwarded = ~cnt_r[2];
          cnt_nxt          = WRITE_NEXT[cnt_r];
          depth_nxt        = decode_depth(cmd_nxt, reg3_nxt);
        end else if (item_i.port_address == PORT_RD_ADDR ||
                     item_i.port_address == PORT_WR_ADDR ||
                     item_i.port_address == PORT_DATA) begin
          cnt_nxt = 3'd0;
        end
      end else begin
        if (is_mask) begin
          case (cnt_r)
            CNT_CMD:    s1_nxt.rd_imm = cmd_r;
            CNT_IDX_LO: s1_nxt.rd_imm = idx_r[7:0];
            CNT_IDX_HI: s1_nxt.rd_imm = idx_r[15:8];
            CNT_DATA: begin
              if (idx_r == 16'd0) begin
                s1_nxt.rd_imm = ID_BYTE0;
              end else if (idx_r == 16'd1) begin
                s1_nxt.rd_imm = ID_BYTE1;
              end else if (in_range) begin
                s1_nxt.use_mem = 1'b1;
                mem_req_o.re   = 1'b1;
              end else begin
                s1_nxt.rd_imm = FILL_BYTE;
              end
              idx_nxt = idx_r + 16'd1;
            end
            default: s1_nxt.rd_imm = FILL_BYTE;
          endcase
          s1_nxt.forwarded = 1'b0;
          cnt_nxt = cmd_r[CMD_EXT_SEQ_BIT] ? READ_NEXT_EXT[cnt_r] : READ_NEXT_PLAIN[cnt_r];
        end else if (item_i.port_address == PORT_WR_ADDR ||
                     item_i.port_address == PORT_DATA) begin
          cnt_nxt = 3'd0;
        end
      end
    end
    s1_nxt.depth_code = depth_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= 3'd0;
      cmd_r      <= 8'h00;
      idx_r      <= 16'h0000;
      reg3_r     <= 8'h00;
      depth_r    <= DEPTH_8BPP;
      s1_valid_r <= 1'b0;
    end else begin
      cnt_r      <= cnt_nxt;
      cmd_r      <= cmd_nxt;
      idx_r      <= idx_nxt;
      reg3_r     <= reg3_nxt;
      depth_r    <= depth_nxt;
      s1_valid_r <= acc_i;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
  end

  assign s1_valid_o = s1_valid_r;
  assign s1_item_o  = s1_r;

  `HRP_ASSERT_IMP(a_single_port_op, mem_req_o.we, !mem_req_o.re,
    "ram write and read issued in the same cycle")
  `HRP_ASSERT_IMP(a_mem_read_issued, s1_valid_r && s1_r.use_mem, $past(mem_req_o.re),
    "stage one takes ram data that was never requested")
  `HRP_ASSERT_IMP(a_forward_quiet, s1_valid_r && s1_r.forwarded,
    !s1_r.use_mem && (s1_r.rd_imm == 8'h00), "forwarded beat carries read data")

endmodule

FILE: src/hrp_outq.sv
`include "ramdac_hidden_register_port_unit_defines.svh"

module hrp_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_i,
  input  hrp_pkg::out_item_t item_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output hrp_pkg::out_item_t out_item_o,
  output logic               block_o
);
  import hrp_pkg::*;

  out_item_t          q_r [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [OUTQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [OUTQ_AW-1:0] count_r, count_nxt;
  logic               pop;

  assign out_valid_o = (count_r != '0);
  assign out_item_o  = q_r[rd_ptr_r];
  assign pop         = out_valid_o && !out_stall_i;

  // room for the beat in stage one plus one more
  assign block_o = ({1'b0, count_r} + {{OUTQ_AW{1'b0}}, push_i}) >= (OUTQ_AW+1)'(OUTQ_DEPTH);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_i) begin
      wr_ptr_nxt = (wr_ptr_r == OUTQ_AW'(OUTQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == OUTQ_AW'(OUTQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_i && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push_i) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      q_r[wr_ptr_r] <= item_i;
    end
  end

  `HRP_ASSERT_IMP(a_no_overflow, count_r == OUTQ_AW'(OUTQ_DEPTH), !push_i,
    "result queue pushed while full")
  `HRP_ASSERT_NXT(a_block_holds_full, count_r == OUTQ_AW'(OUTQ_DEPTH) && out_stall_i,
    count_r == OUTQ_AW'(OUTQ_DEPTH), "full queue lost a beat while stalled")

endmodule
